// ===== hdl/rti_pkg.sv =====
// rti_pkg: shared constants for the ray/segment versus triangle tester.
// Used by every module under hdl/; has no dependencies of its own.

package rti_pkg;

   // stream word layout
   localparam int VEC_BITS       = 63;   // one packed z:y:x vector
   localparam int REQ_TDATA_BITS = 320;  // five vectors, padded to bytes
   localparam int RSP_TDATA_BITS = 8;    // hit flag, padded to a byte

   // default coordinate width (two's complement, fixed point)
   localparam int COORD_BITS_DEFAULT = 21;

   // op codes carried on req_tuser
   localparam logic OP_RAY     = 1'b0;
   localparam logic OP_SEGMENT = 1'b1;

   // CSR map
   localparam int          CSR_ADDR_BITS       = 3;
   localparam int          CSR_DATA_BITS       = 32;
   localparam logic        CSR_DET_THRESHOLD   = 1'b0;  // register index, paddr[2]
   localparam int          DET_THRESHOLD_BITS  = 20;
   localparam logic [19:0] DET_THRESHOLD_RESET = 20'd1074;

endpackage

// ===== hdl/rti_diff.sv =====
// rti_diff: input register stage; unpacks the vectors and forms the edges
// E1, E2, the direction D and T = O - A. Depends on rti_pkg.

module rti_diff #(
   parameter int CW = rti_pkg::COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          op,
   input  logic [rti_pkg::VEC_BITS-1:0]  origin_point,
   input  logic [rti_pkg::VEC_BITS-1:0]  second_vector,
   input  logic [rti_pkg::VEC_BITS-1:0]  vertex_a,
   input  logic [rti_pkg::VEC_BITS-1:0]  vertex_b,
   input  logic [rti_pkg::VEC_BITS-1:0]  vertex_c,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic                          seg,
   output logic signed [CW:0]            e1 [3],
   output logic signed [CW:0]            e2 [3],
   output logic signed [CW:0]            d [3],
   output logic signed [CW:0]            tv [3]
);

   logic signed [CW-1:0] oc [3];
   logic signed [CW-1:0] sc [3];
   logic signed [CW-1:0] ac [3];
   logic signed [CW-1:0] bc [3];
   logic signed [CW-1:0] cc [3];

   logic                 vld_ff, vld_in;
   logic                 seg_ff;
   logic signed [CW:0]   e1_ff [3], e1_in [3];
   logic signed [CW:0]   e2_ff [3], e2_in [3];
   logic signed [CW:0]   d_ff [3], d_in [3];
   logic signed [CW:0]   tv_ff [3], tv_in [3];

   assign in_ready = !vld_ff || out_ready;
   assign vld_in   = in_ready ? in_valid : vld_ff;

   // bits above 3*CW are ignored
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         oc[i] = $signed(origin_point[CW*i +: CW]);
         sc[i] = $signed(second_vector[CW*i +: CW]);
         ac[i] = $signed(vertex_a[CW*i +: CW]);
         bc[i] = $signed(vertex_b[CW*i +: CW]);
         cc[i] = $signed(vertex_c[CW*i +: CW]);
      end
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = (CW+1)'(bc[i]) - (CW+1)'(ac[i]);
         e2_in[i] = (CW+1)'(cc[i]) - (CW+1)'(ac[i]);
         tv_in[i] = (CW+1)'(oc[i]) - (CW+1)'(ac[i]);
         if (op == rti_pkg::OP_SEGMENT) begin
            d_in[i] = (CW+1)'(sc[i]) - (CW+1)'(oc[i]);
         end else begin
            d_in[i] = (CW+1)'(sc[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         seg_ff <= (op == rti_pkg::OP_SEGMENT);
         e1_ff  <= e1_in;
         e2_ff  <= e2_in;
         d_ff   <= d_in;
         tv_ff  <= tv_in;
      end
   end

   assign out_valid = vld_ff;
   assign seg       = seg_ff;
   assign e1        = e1_ff;
   assign e2        = e2_ff;
   assign d         = d_ff;
   assign tv        = tv_ff;

endmodule

// ===== hdl/rti_cross.sv =====
// rti_cross: two stages forming P = D x E2 and Q = T x E1; multiply, then
// subtract. Edge vectors ride along. Depends on rti_pkg.

module rti_cross #(
   parameter int CW = rti_pkg::COORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic                  in_seg,
   input  logic signed [CW:0]    in_e1 [3],
   input  logic signed [CW:0]    in_e2 [3],
   input  logic signed [CW:0]    in_d [3],
   input  logic signed [CW:0]    in_tv [3],
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic                  seg,
   output logic signed [CW:0]    e1 [3],
   output logic signed [CW:0]    e2 [3],
   output logic signed [CW:0]    d [3],
   output logic signed [CW:0]    tv [3],
   output logic signed [2*CW+2:0] pv [3],
   output logic signed [2*CW+2:0] qv [3]
);

   localparam int NS = 2;
   localparam int MW = 2*CW + 2;   // product width
   localparam int PW = 2*CW + 3;   // cross component width

   logic [NS-1:0] vld_ff, vld_in;
   logic [NS:0]   rdy;

   // stage 1: products, [component][term]
   logic signed [MW-1:0] pp_ff [3][2], pp_in [3][2];
   logic signed [MW-1:0] qp_ff [3][2], qp_in [3][2];
   logic                 s1_seg_ff;
   logic signed [CW:0]   s1_e1_ff [3], s1_e2_ff [3], s1_d_ff [3], s1_tv_ff [3];

   // stage 2: cross vectors
   logic signed [PW-1:0] pv_ff [3], pv_in [3];
   logic signed [PW-1:0] qv_ff [3], qv_in [3];
   logic                 s2_seg_ff;
   logic signed [CW:0]   s2_e1_ff [3], s2_e2_ff [3], s2_d_ff [3], s2_tv_ff [3];

   always_comb begin
      rdy[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in[0] = rdy[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < NS; k++) begin
         vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      pp_in[0][0] = in_d[1] * in_e2[2];
      pp_in[0][1] = in_d[2] * in_e2[1];
      pp_in[1][0] = in_d[2] * in_e2[0];
      pp_in[1][1] = in_d[0] * in_e2[2];
      pp_in[2][0] = in_d[0] * in_e2[1];
      pp_in[2][1] = in_d[1] * in_e2[0];
      qp_in[0][0] = in_tv[1] * in_e1[2];
      qp_in[0][1] = in_tv[2] * in_e1[1];
      qp_in[1][0] = in_tv[2] * in_e1[0];
      qp_in[1][1] = in_tv[0] * in_e1[2];
      qp_in[2][0] = in_tv[0] * in_e1[1];
      qp_in[2][1] = in_tv[1] * in_e1[0];
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pv_in[i] = PW'(pp_ff[i][0]) - PW'(pp_ff[i][1]);
         qv_in[i] = PW'(qp_ff[i][0]) - PW'(qp_ff[i][1]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         pp_ff     <= pp_in;
         qp_ff     <= qp_in;
         s1_seg_ff <= in_seg;
         s1_e1_ff  <= in_e1;
         s1_e2_ff  <= in_e2;
         s1_d_ff   <= in_d;
         s1_tv_ff  <= in_tv;
      end
      if (rdy[1]) begin
         pv_ff     <= pv_in;
         qv_ff     <= qv_in;
         s2_seg_ff <= s1_seg_ff;
         s2_e1_ff  <= s1_e1_ff;
         s2_e2_ff  <= s1_e2_ff;
         s2_d_ff   <= s1_d_ff;
         s2_tv_ff  <= s1_tv_ff;
      end
   end

   assign seg = s2_seg_ff;
   assign e1  = s2_e1_ff;
   assign e2  = s2_e2_ff;
   assign d   = s2_d_ff;
   assign tv  = s2_tv_ff;
   assign pv  = pv_ff;
   assign qv  = qv_ff;

endmodule

// ===== hdl/rti_dot.sv =====
// rti_dot: three stages forming det = E1.P, un = T.P, vn = D.Q, tn = E2.Q.
// Each wide product is split in two half products. Depends on rti_pkg.

module rti_dot #(
   parameter int CW = rti_pkg::COORD_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic                   in_seg,
   input  logic signed [CW:0]     in_e1 [3],
   input  logic signed [CW:0]     in_e2 [3],
   input  logic signed [CW:0]     in_d [3],
   input  logic signed [CW:0]     in_tv [3],
   input  logic signed [2*CW+2:0] in_pv [3],
   input  logic signed [2*CW+2:0] in_qv [3],
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic                   seg,
   output logic signed [3*CW+6:0] det,
   output logic signed [3*CW+6:0] un,
   output logic signed [3*CW+6:0] vn,
   output logic signed [3*CW+6:0] tn
);

   localparam int NS  = 3;
   localparam int PW  = 2*CW + 3;   // cross component width
   localparam int LB  = CW + 2;     // low slice of a cross component
   localparam int LOW = CW + LB + 2; // low half product width
   localparam int HIW = 2*CW + 2;   // high half product width
   localparam int DW  = 3*CW + 7;   // dot product width

   logic [NS-1:0] vld_ff, vld_in;
   logic [NS:0]   rdy;

   // operand pairs: 0 det, 1 un, 2 vn, 3 tn
   logic signed [CW:0]     av [4][3];
   logic signed [PW-1:0]   bv [4][3];

   logic signed [LOW-1:0]  lo_ff [4][3], lo_in [4][3];
   logic signed [HIW-1:0]  hi_ff [4][3], hi_in [4][3];
   logic signed [DW-1:0]   pr_ff [4][3], pr_in [4][3];
   logic signed [DW-1:0]   dt_ff [4], dt_in [4];
   logic [NS-1:0]          seg_ff;

   always_comb begin
      rdy[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in[0] = rdy[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < NS; k++) begin
         vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         av[0][i] = in_e1[i];
         bv[0][i] = in_pv[i];
         av[1][i] = in_tv[i];
         bv[1][i] = in_pv[i];
         av[2][i] = in_d[i];
         bv[2][i] = in_qv[i];
         av[3][i] = in_e2[i];
         bv[3][i] = in_qv[i];
      end
   end

   // low slice is unsigned, high slice carries the sign
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 3; i++) begin
            lo_in[k][i] = av[k][i] * $signed({1'b0, bv[k][i][LB-1:0]});
            hi_in[k][i] = av[k][i] * $signed(bv[k][i][PW-1:LB]);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 3; i++) begin
            pr_in[k][i] = (DW'(hi_ff[k][i]) <<< LB) + DW'(lo_ff[k][i]);
         end
         dt_in[k] = pr_ff[k][0] + pr_ff[k][1] + pr_ff[k][2];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
         seg_ff[0] <= in_seg;
      end
      if (rdy[1]) begin
         pr_ff     <= pr_in;
         seg_ff[1] <= seg_ff[0];
      end
      if (rdy[2]) begin
         dt_ff     <= dt_in;
         seg_ff[2] <= seg_ff[1];
      end
   end

   assign seg = seg_ff[NS-1];
   assign det = dt_ff[0];
   assign un  = dt_ff[1];
   assign vn  = dt_ff[2];
   assign tn  = dt_ff[3];

endmodule

// ===== hdl/rti_decide.sv =====
// rti_decide: sign fold of det, un, vn, tn, then the bound compares; the
// last stage is the result register. Depends on rti_pkg.

module rti_decide #(
   parameter int CW = rti_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [rti_pkg::DET_THRESHOLD_BITS-1:0] det_threshold,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic                                  in_seg,
   input  logic signed [3*CW+6:0]                in_det,
   input  logic signed [3*CW+6:0]                in_un,
   input  logic signed [3*CW+6:0]                in_vn,
   input  logic signed [3*CW+6:0]                in_tn,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic                                  hit
);

   localparam int NS = 2;
   localparam int DW = 3*CW + 7;

   logic [NS-1:0] vld_ff, vld_in;
   logic [NS:0]   rdy;

   logic signed [DW-1:0] det_ff, det_in;
   logic signed [DW-1:0] un_ff, un_in;
   logic signed [DW-1:0] vn_ff, vn_in;
   logic signed [DW-1:0] tn_ff, tn_in;
   logic                 seg_ff;
   logic signed [DW:0]   uv;
   logic signed [DW-1:0] thr_w;
   logic                 hit_ff, hit_in;

   always_comb begin
      rdy[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in[0] = rdy[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < NS; k++) begin
         vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // a negative det flips all four, so the bounds compare against |det|
   always_comb begin
      if (in_det[DW-1]) begin
         det_in = -in_det;
         un_in  = -in_un;
         vn_in  = -in_vn;
         tn_in  = -in_tn;
      end else begin
         det_in = in_det;
         un_in  = in_un;
         vn_in  = in_vn;
         tn_in  = in_tn;
      end
   end

   always_comb begin
      thr_w  = $signed(DW'(det_threshold));
      uv     = (DW+1)'(un_ff) + (DW+1)'(vn_ff);
      hit_in = (det_ff != '0) && (det_ff >= thr_w)
             && !un_ff[DW-1] && (det_ff >= un_ff)
             && !vn_ff[DW-1] && ((DW+1)'(det_ff) >= uv)
             && !tn_ff[DW-1] && (tn_ff != '0)
             && (!seg_ff || (tn_ff < det_ff));
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         det_ff <= det_in;
         un_ff  <= un_in;
         vn_ff  <= vn_in;
         tn_ff  <= tn_in;
         seg_ff <= in_seg;
      end
      if (rdy[1]) begin
         hit_ff <= hit_in;
      end
   end

   assign hit = hit_ff;

endmodule

// ===== hdl/ray_triangle_intersect.sv =====
// ray_triangle_intersect: top level of the ray/segment versus triangle
// tester; CSR block and the four pipeline sections. Depends on rti_pkg.
//
//   channel  | dir | words                                 | handshake
//   req_     | in  | five packed vectors + op (tuser)      | tvalid/tready
//   rsp_     | out | hit flag                              | tvalid/tready
//   csr_     | in  | det_threshold at byte address 0       | APB, pready tied high
//
// Eight register stages: input register, two for the cross products, three
// for the split dot products, one for the sign fold and the result register.
// One word per cycle in, one out, while the rsp_ side is not stalled.
// Each stage takes a new word whenever it is empty or its successor moves,
// so bubbles close up under a stalled rsp_ side.
// Synchronous reset empties the pipeline and loads det_threshold with 1074.

module ray_triangle_intersect #(
   parameter int COORD_BITS = rti_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata, low bit up: origin_point, second_vector, vertex_a,
   // vertex_b, vertex_c (63 bits each), zero pad
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [rti_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   input  logic                                 req_tuser,   // op
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rti_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,   // hit, zero pad
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rti_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [rti_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [rti_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   localparam int CW = COORD_BITS;
   localparam int VB = rti_pkg::VEC_BITS;
   localparam int TB = rti_pkg::DET_THRESHOLD_BITS;

   logic [TB-1:0] thr_ff, thr_in;
   logic          csr_hit;

   // diff -> cross
   logic                 dc_valid, dc_ready, dc_seg;
   logic signed [CW:0]   dc_e1 [3], dc_e2 [3], dc_d [3], dc_tv [3];
   // cross -> dot
   logic                 cd_valid, cd_ready, cd_seg;
   logic signed [CW:0]   cd_e1 [3], cd_e2 [3], cd_d [3], cd_tv [3];
   logic signed [2*CW+2:0] cd_pv [3], cd_qv [3];
   // dot -> decide
   logic                 dd_valid, dd_ready, dd_seg;
   logic signed [3*CW+6:0] dd_det, dd_un, dd_vn, dd_tn;
   logic                 hit;

   // ---- CSR ----
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == rti_pkg::CSR_DET_THRESHOLD);

   always_comb begin
      thr_in = thr_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         thr_in = csr_pwdata[TB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= rti_pkg::DET_THRESHOLD_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign csr_prdata = csr_hit ? rti_pkg::CSR_DATA_BITS'(thr_ff) : '0;

   // ---- pipeline ----
   rti_diff #(.CW(CW)) u_diff (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .op            (req_tuser),
      .origin_point  (req_tdata[0*VB +: VB]),
      .second_vector (req_tdata[1*VB +: VB]),
      .vertex_a      (req_tdata[2*VB +: VB]),
      .vertex_b      (req_tdata[3*VB +: VB]),
      .vertex_c      (req_tdata[4*VB +: VB]),
      .out_valid     (dc_valid),
      .out_ready     (dc_ready),
      .seg           (dc_seg),
      .e1            (dc_e1),
      .e2            (dc_e2),
      .d             (dc_d),
      .tv            (dc_tv)
   );

   rti_cross #(.CW(CW)) u_cross (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dc_valid),
      .in_ready  (dc_ready),
      .in_seg    (dc_seg),
      .in_e1     (dc_e1),
      .in_e2     (dc_e2),
      .in_d      (dc_d),
      .in_tv     (dc_tv),
      .out_valid (cd_valid),
      .out_ready (cd_ready),
      .seg       (cd_seg),
      .e1        (cd_e1),
      .e2        (cd_e2),
      .d         (cd_d),
      .tv        (cd_tv),
      .pv        (cd_pv),
      .qv        (cd_qv)
   );

   rti_dot #(.CW(CW)) u_dot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cd_valid),
      .in_ready  (cd_ready),
      .in_seg    (cd_seg),
      .in_e1     (cd_e1),
      .in_e2     (cd_e2),
      .in_d      (cd_d),
      .in_tv     (cd_tv),
      .in_pv     (cd_pv),
      .in_qv     (cd_qv),
      .out_valid (dd_valid),
      .out_ready (dd_ready),
      .seg       (dd_seg),
      .det       (dd_det),
      .un        (dd_un),
      .vn        (dd_vn),
      .tn        (dd_tn)
   );

   rti_decide #(.CW(CW)) u_decide (
      .clock         (clock),
      .reset         (reset),
      .det_threshold (thr_ff),
      .in_valid      (dd_valid),
      .in_ready      (dd_ready),
      .in_seg        (dd_seg),
      .in_det        (dd_det),
      .in_un         (dd_un),
      .in_vn         (dd_vn),
      .in_tn         (dd_tn),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .hit           (hit)
   );

   assign rsp_tdata = rti_pkg::RSP_TDATA_BITS'(hit);

endmodule

// ===== hdl/rti_checker.sv =====
// rti_checker: port-level assertions for ray_triangle_intersect, attached
// by the bind at the end of this file. Depends on rti_pkg.

module rti_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [rti_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   input logic                               req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [rti_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input logic                               csr_psel,
   input logic                               csr_penable,
   input logic                               csr_pwrite,
   input logic [rti_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input logic [rti_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   input logic [rti_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   input logic                               csr_pready
);

   localparam int TB = rti_pkg::DET_THRESHOLD_BITS;

   // a held result word keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // only the hit bit may be set in a result word
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[rti_pkg::RSP_TDATA_BITS-1:1] == '0))
      else $error("rsp pad bits set");

   // threshold write is visible on readback the next cycle
   a_thr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready
      && (csr_paddr[2] == rti_pkg::CSR_DET_THRESHOLD)
      |=> (csr_paddr[2] != rti_pkg::CSR_DET_THRESHOLD)
          || (csr_prdata == rti_pkg::CSR_DATA_BITS'($past(csr_pwdata[TB-1:0]))))
      else $error("det_threshold readback mismatch");

   // stalled input side must not swallow words: tready low only with a stall
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without output stall");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (.*);
